FILE: rtl/assd_pkg.sv
`default_nettype none

package assd_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;

  // Widths of the fixed item fields.
  localparam int IN_IDX_W  = 7;
  localparam int OUT_CNT_W = 7;
  localparam int OUT_VAL_W = 32;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  // Read tree: words per first-level group.
  localparam int Grp  = 8;
  localparam int NGRP = (DEPTH + Grp - 1) / Grp;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_READ      = 3'd1,
    OP_SORT_ASC  = 3'd2,
    OP_SORT_DESC = 3'd3,
    OP_DELETE    = 3'd4,
    OP_INSERT    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SORT
  } cell_op_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e          op;
    logic [CMP_W-1:0]  idx;
    logic [CMP_W-1:0]  count;
    word_t             value;
    logic              desc;
    logic              phase;
  } cell_cmd_t;

  // Sign-extend (or cut) a stored word to the result width.
  function automatic logic [OUT_VAL_W-1:0] to_read_value(input word_t w);
    return OUT_VAL_W'(w);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/assd_in_if.sv
`default_nettype none

interface assd_in_if import assd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [2:0]                 op;
  logic [IN_IDX_W-1:0]        index;
  logic signed [OUT_VAL_W-1:0] value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/assd_out_if.sv
`default_nettype none

interface assd_out_if import assd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_VAL_W-1:0] read_value;
  logic [OUT_CNT_W-1:0]        count;
  logic [1:0]                  status;

  modport source (output valid, output read_value, output count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input count, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/assd_cell.sv
`default_nettype none

module assd_cell import assd_pkg::*; (
  input  wire logic      clk_i,
  input  wire cell_cmd_t cmd_i,
  input  wire logic [IDX_W-1:0] pos_i,
  input  wire word_t     left_i,
  input  wire word_t     right_i,
  output word_t          word_o
);

  word_t            word_q, word_d;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] pos_nx;
  logic             swap;

  assign pos    = CMP_W'(pos_i);
  assign pos_nx = pos + CMP_W'(1);

  always_comb begin
    word_d = word_q;
    swap   = 1'b0;
    case (cmd_i.op)
      CELL_WRITE: begin
        if (pos == cmd_i.idx) word_d = cmd_i.value;
      end
      CELL_INSERT: begin
        if (pos == cmd_i.idx) begin
          word_d = cmd_i.value;
        end else if (pos > cmd_i.idx && pos <= cmd_i.count) begin
          word_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (pos >= cmd_i.idx && pos_nx < cmd_i.count) word_d = right_i;
      end
      CELL_SORT: begin
        if (pos_i[0] == cmd_i.phase) begin
          // lower member of the pair: keep the smaller (ascending)
          if (pos_nx < cmd_i.count) begin
            swap = cmd_i.desc ? (word_q < right_i) : (word_q > right_i);
            if (swap) word_d = right_i;
          end
        end else begin
          // upper member of the pair: keep the larger (ascending)
          if (pos != '0 && pos < cmd_i.count) begin
            swap = cmd_i.desc ? (left_i < word_q) : (left_i > word_q);
            if (swap) word_d = left_i;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

FILE: rtl/assd_read_tree.sv
`default_nettype none

module assd_read_tree import assd_pkg::*; (
  input  wire logic             clk_i,
  input  wire word_t            words_i [DEPTH],
  input  wire logic [CMP_W-1:0] sel_i,
  output word_t                 rd_o
);

  word_t grp_q [NGRP];
  word_t grp_d [NGRP];
  word_t rd_q, rd_d;

  // First level: mask every word but the selected one, OR within groups.
  always_comb begin
    for (int g = 0; g < NGRP; g++) grp_d[g] = '0;
    for (int e = 0; e < DEPTH; e++) begin
      if (sel_i == CMP_W'(e)) grp_d[e / Grp] = grp_d[e / Grp] | words_i[e];
    end
  end

  always_comb begin
    rd_d = '0;
    for (int g = 0; g < NGRP; g++) rd_d = rd_d | grp_q[g];
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    rd_q  <= rd_d;
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/array_store_sort_insert_delete_top.sv
`default_nettype none

// Array store with sort, insert and delete. The words live in a row of DEPTH
// cells; each cell holds one word and sees the words of its two neighbours,
// so append, insert (later words move up) and delete (later words move down)
// are each applied in a single step of the row, and a sort runs as odd-even
// transposition over DEPTH passes of the row, every cell comparing with its
// pair partner in each pass. One item is worked at a time: a transfer on the
// input takes the item in, the EXEC state decodes and applies it, a result
// then loads the output register. Append, insert, delete and the unused op
// codes go from EXEC straight to DONE; read passes through RD, as it goes
// through a two-stage registered OR tree over the cells; sort runs its DEPTH
// passes in SORT, set by the pass counter. A new item is taken while the
// previous result still waits in the output register.
// Results give the word read (zero unless a good read), the fill count after
// the operation and a status: ok, index out of range, or store full; on an
// error the array is left untouched. Cells have no reset: only words below
// the fill count are ever read.
module array_store_sort_insert_delete_top import assd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  assd_in_if.sink     in_i,
  assd_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SORT,
    ST_RD,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [2:0]          op_q;
  logic [CMP_W-1:0]    idx_q;
  word_t               val_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    pass_q;
  status_e             status_q, status_d;

  logic                out_valid_q;
  logic [OUT_VAL_W-1:0] out_value_q;
  logic [OUT_CNT_W-1:0] out_count_q;
  status_e             out_status_q;

  cell_cmd_t           cell_cmd;
  word_t               words [DEPTH];
  word_t               rd_word;

  logic [CMP_W-1:0]    count_x;
  logic                idx_lt_cnt;
  logic                idx_le_cnt;
  logic                full;

  assign count_x    = CMP_W'(count_q);
  assign idx_lt_cnt = idx_q < count_x;
  assign idx_le_cnt = idx_q <= count_x;
  assign full       = count_q == CNT_W'(DEPTH);

  // Decode the held item; drive the cell row for the shifting ops in EXEC
  // and for one transposition pass per cycle in SORT.
  always_comb begin
    status_d       = STAT_OK;
    count_d        = count_q;
    cell_cmd.op    = CELL_HOLD;
    cell_cmd.idx   = idx_q;
    cell_cmd.count = count_x;
    cell_cmd.value = val_q;
    cell_cmd.desc  = (op_q == OP_SORT_DESC);
    cell_cmd.phase = pass_q[0];
    if (state_q == ST_EXEC) begin
      case (op_q)
        OP_APPEND: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            cell_cmd.op  = CELL_WRITE;
            cell_cmd.idx = count_x;
            count_d      = count_q + CNT_W'(1);
          end
        end
        OP_READ: begin
          if (!idx_lt_cnt) status_d = STAT_RANGE;
        end
        OP_DELETE: begin
          if (idx_lt_cnt) begin
            cell_cmd.op = CELL_DELETE;
            count_d     = count_q - CNT_W'(1);
          end else begin
            status_d = STAT_RANGE;
          end
        end
        OP_INSERT: begin
          if (!idx_le_cnt) begin
            status_d = STAT_RANGE;
          end else if (full) begin
            status_d = STAT_FULL;
          end else begin
            cell_cmd.op = CELL_INSERT;
            count_d     = count_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end else if (state_q == ST_SORT) begin
      cell_cmd.op = CELL_SORT;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_row
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[g+1];
    end
    assd_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .pos_i   (IDX_W'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[g])
    );
  end

  assd_read_tree u_read_tree (
    .clk_i   (clk_i),
    .words_i (words),
    .sel_i   (idx_q),
    .rd_o    (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once the sink has taken it; DONE reloads it itself
      if (out_valid_q && out_o.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.op;
            idx_q   <= CMP_W'(in_i.index);
            val_q   <= WORD_BITS'(in_i.value);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          status_q <= status_d;
          count_q  <= count_d;
          pass_q   <= '0;
          if (op_q == OP_SORT_ASC || op_q == OP_SORT_DESC) begin
            state_q <= ST_SORT;
          end else if (op_q == OP_READ) begin
            state_q <= ST_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SORT: begin
          pass_q <= pass_q + IDX_W'(1);
          if (pass_q == IDX_W'(DEPTH - 1)) state_q <= ST_DONE;
        end
        ST_RD: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= (op_q == OP_READ && status_q == STAT_OK)
                            ? to_read_value(rd_word) : '0;
            out_count_q  <= OUT_CNT_W'(count_q);
            out_status_q <= status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.count      = out_count_q;
  assign out_o.status     = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_sort_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SORT |=> count_q == $past(count_q))
    else $error("fill count changed during sort");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == STAT_FULL |-> out_count_q == OUT_CNT_W'(DEPTH))
    else $error("store full reported below depth");

  a_err_zero_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != STAT_OK |-> out_value_q == '0)
    else $error("read value not zero on error");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_EXEC)
    else $error("transfer accepted outside idle");

endmodule

`default_nettype wire

FILE: dv/tb_array_store_sort_insert_delete_top.sv
`default_nettype none

module tb_array_store_sort_insert_delete_top;
  timeunit 1ns;
  timeprecision 1ps;

  import assd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 600;
  // Worst case is a sort per item plus sender and receiver gaps.
  localparam int CYCLE_LIMIT  = 400000;
  // A sort is the slowest operation, so let that many cycles pass after the last result.
  localparam int DRAIN_CYCLES = DEPTH + 8;
  // Accepted items per idling phase; the phases cycle through all four kinds.
  localparam int PHASE_LEN    = 90;
  // Long receiver hold-off: starts once this many items are in, lasts this many cycles.
  localparam int HOLD_AT      = 380;
  localparam int HOLD_CYCLES  = 300;

  // Op codes the block decodes as no-ops.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_GAPS
  } gap_phase_e;

  typedef struct packed {
    logic [2:0]           op;
    logic [IN_IDX_W-1:0]  index;
    logic [OUT_VAL_W-1:0] value;
  } array_op_t;

  typedef struct packed {
    logic [OUT_VAL_W-1:0] read_value;
    logic [OUT_CNT_W-1:0] count;
    status_e              status;
  } array_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  assd_in_if  in_if ();
  assd_out_if out_if ();

  array_store_sort_insert_delete_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // Registers behind the block's inputs; the initialisers keep every input known from time 0.
  logic                 drv_valid = 1'b0;
  logic [2:0]           drv_op    = '0;
  logic [IN_IDX_W-1:0]  drv_index = '0;
  logic [OUT_VAL_W-1:0] drv_value = '0;
  logic                 rcv_ready = 1'b0;

  assign in_if.valid  = drv_valid;
  assign in_if.op     = drv_op;
  assign in_if.index  = drv_index;
  assign in_if.value  = drv_value;
  assign out_if.ready = rcv_ready;

  // Shadow of the array, updated once per accepted transfer.
  word_t         shadow_words [DEPTH];
  int            shadow_fill = 0;

  array_op_t     pending_ops [$];
  array_result_t expected_results [$];

  int n_errors    = 0;
  int n_accepted  = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  // Fill count as the stimulus generator sees it, so that it can aim indices.
  int gen_fill    = 0;
  int n_queued    = 0;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Release reset away from the rising edge so that no process races it.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: apply one operation to the shadow array and give its result
  // ---------------------------------------------------------------------------
  function automatic array_result_t apply_array_op(input array_op_t item);
    array_result_t        res;
    int                   idx;
    int                   i;
    int                   j;
    bit                   desc;
    logic signed [63:0]   wide;
    word_t                w;
    word_t                tmp;
    res.read_value = '0;
    res.status     = STAT_OK;
    idx            = int'(item.index);
    // Sign-extend the 32-bit input word, then keep the stored width.
    wide           = signed'(item.value);
    w              = wide[WORD_BITS-1:0];
    case (item.op)
      OP_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          shadow_words[shadow_fill] = w;
          shadow_fill++;
        end
      end
      OP_READ: begin
        if (idx < shadow_fill) begin
          wide           = shadow_words[idx];
          res.read_value = wide[OUT_VAL_W-1:0];
        end else begin
          res.status = STAT_RANGE;
        end
      end
      OP_SORT_ASC, OP_SORT_DESC: begin
        desc = (item.op == OP_SORT_DESC);
        for (i = 0; i < shadow_fill; i++) begin
          for (j = 0; j + 1 < shadow_fill - i; j++) begin
            if (desc ? (shadow_words[j] < shadow_words[j+1])
                     : (shadow_words[j] > shadow_words[j+1])) begin
              tmp               = shadow_words[j];
              shadow_words[j]   = shadow_words[j+1];
              shadow_words[j+1] = tmp;
            end
          end
        end
      end
      OP_DELETE: begin
        if (idx < shadow_fill) begin
          for (i = idx; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
        end else begin
          res.status = STAT_RANGE;
        end
      end
      OP_INSERT: begin
        // The index check wins over the full check.
        if (idx > shadow_fill) begin
          res.status = STAT_RANGE;
        end else if (shadow_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (i = shadow_fill; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = w;
          shadow_fill++;
        end
      end
      default: begin
      end
    endcase
    res.count = OUT_CNT_W'(shadow_fill);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Queue one operation and track the fill count it leaves behind.
  task automatic queue_op(input logic [2:0] op, input int idx, input logic [31:0] val);
    array_op_t item;
    item.op    = op;
    item.index = IN_IDX_W'(idx);
    item.value = val;
    pending_ops.push_back(item);
    case (op)
      OP_APPEND: if (gen_fill < DEPTH) gen_fill++;
      OP_DELETE: if (idx < gen_fill) gen_fill--;
      OP_INSERT: if (idx <= gen_fill && gen_fill < DEPTH) gen_fill++;
      default: begin
      end
    endcase
    // Spare codes are ignored by the block; leave them out of the tally.
    if (op <= OP_INSERT) n_queued++;
  endtask

  // Bias towards extremes and a narrow band, so that sorts meet equal words.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($urandom_range(15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Uniform index below span; zero when span is empty.
  function automatic int pick_index(input int span);
    return (span > 0) ? int'($urandom_range(span - 1)) : 0;
  endfunction

  function automatic gap_phase_e gap_phase();
    return gap_phase_e'((n_accepted / PHASE_LEN) % 4);
  endfunction

  function automatic int send_gap_pct();
    case (gap_phase())
      PH_SEND_GAPS: return 61;
      PH_BOTH_GAPS: return 23;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (gap_phase())
      PH_RECV_STALLS: return 61;
      PH_BOTH_GAPS:   return 23;
      default:        return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next pending op, hold it until the transfer happens
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    array_op_t     nxt;
    array_op_t     cur;
    array_result_t res;
    bit            gap;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      // Predict at the transfer, from the op that was on the bus.
      if (drv_valid && in_if.ready) begin
        cur.op    = drv_op;
        cur.index = drv_index;
        cur.value = drv_value;
        res       = apply_array_op(cur);
        expected_results.push_back(res);
        n_accepted <= n_accepted + 1;
      end
      // Only move on once the bus is free; one assignment per signal per edge.
      if (!drv_valid || in_if.ready) begin
        gap = (int'($urandom_range(99)) < send_gap_pct());
        if (pending_ops.size() != 0 && !gap) begin
          nxt       = pending_ops.pop_front();
          drv_valid <= 1'b1;
          drv_op    <= nxt.op;
          drv_index <= nxt.index;
          drv_value <= nxt.value;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure
  // ---------------------------------------------------------------------------
  // Count down the long hold-off; it starts once during a gap-free phase, so
  // the sender keeps offering and the block fills up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= (hold_left == 0) && !(int'($urandom_range(99)) < recv_stall_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    array_result_t want;
    if (rst_ni && out_if.valid && rcv_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_if.read_value), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_if.read_value !== want.read_value)
          report_mismatch("read_value", 64'(out_if.read_value), 64'(want.read_value));
        if (out_if.count !== want.count)
          report_mismatch("count", 64'(out_if.count), 64'(want.count));
        if (out_if.status !== want.status)
          report_mismatch("status", 64'(out_if.status), 64'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[array_store_sort_insert_delete_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int kind;
    int r;
    int n;
    // Directed: empty store, extremes, every op, spare codes, boundaries.
    queue_op(OP_READ, 0, 32'd0);                 // read on empty store
    queue_op(OP_DELETE, 0, 32'd0);               // delete on empty store
    queue_op(OP_SORT_ASC, 0, 32'd0);             // sort with nothing stored
    queue_op(OP_INSERT, 1, 32'd1);               // insert past the count
    queue_op(OP_INSERT, 0, 32'h7fff_ffff);
    queue_op(OP_APPEND, 0, 32'h8000_0000);
    queue_op(OP_APPEND, 0, 32'h0000_0000);
    queue_op(OP_APPEND, 0, 32'hffff_ffff);
    queue_op(OP_INSERT, 4, 32'd5);               // insert at the count
    queue_op(OP_SPARE_6, 127, 32'hffff_ffff);
    queue_op(OP_SPARE_7, 0, 32'h0000_0000);
    queue_op(OP_READ, 4, 32'hffff_ffff);
    queue_op(OP_READ, 5, 32'd0);                 // read at the count
    queue_op(OP_READ, 127, 32'd0);
    queue_op(OP_SORT_ASC, 0, 32'd0);
    queue_op(OP_READ, 0, 32'd0);
    queue_op(OP_SORT_DESC, 127, 32'd0);
    queue_op(OP_READ, 4, 32'd0);
    queue_op(OP_DELETE, 127, 32'd0);
    queue_op(OP_DELETE, 4, 32'd0);
    queue_op(OP_DELETE, 0, 32'd0);
    // Fill the store, then hit both full cases and the index-before-full rule.
    while (gen_fill < DEPTH) queue_op(OP_APPEND, 0, rand_word());
    queue_op(OP_APPEND, 0, 32'd7);
    queue_op(OP_INSERT, DEPTH + 1, 32'd7);
    queue_op(OP_INSERT, 10, 32'd7);
    queue_op(OP_INSERT, DEPTH, 32'd7);
    queue_op(OP_READ, DEPTH - 1, 32'd0);
    queue_op(OP_DELETE, DEPTH - 1, 32'd0);
    queue_op(OP_INSERT, DEPTH - 1, 32'h8000_0000);

    // Random: mostly well-formed ops aimed at valid indices, with fill and
    // drain bursts to walk the whole count range, plus edge probes and noise.
    n_queued = 0;
    while (n_queued < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        while (gen_fill < DEPTH && n_queued < RANDOM_ITEMS)
          queue_op(OP_APPEND, 0, rand_word());
        queue_op(OP_APPEND, 0, rand_word());
        queue_op(OP_INSERT, pick_index(gen_fill + 1), rand_word());
      end else if (kind < 16) begin
        n = $urandom_range(gen_fill + 1, 1);
        repeat (n) queue_op(OP_DELETE, pick_index(gen_fill), 32'($urandom));
      end else if (kind < 24) begin
        queue_op($urandom_range(1) ? OP_SORT_ASC : OP_SORT_DESC, $urandom_range(127),
                 $urandom);
        repeat ($urandom_range(4, 1)) queue_op(OP_READ, pick_index(gen_fill), $urandom);
      end else if (kind < 30) begin
        // Just past the valid range for each indexed op.
        case ($urandom_range(2))
          0:       queue_op(OP_READ, gen_fill, $urandom);
          1:       queue_op(OP_DELETE, gen_fill, $urandom);
          default: queue_op(OP_INSERT, gen_fill + 1, rand_word());
        endcase
      end else if (kind < 92) begin
        r = $urandom_range(99);
        if (r < 25)      queue_op(OP_APPEND, $urandom_range(127), rand_word());
        else if (r < 50) queue_op(OP_READ, pick_index(gen_fill), $urandom);
        else if (r < 65) queue_op(OP_DELETE, pick_index(gen_fill), $urandom);
        else if (r < 88) queue_op(OP_INSERT, pick_index(gen_fill + 1), rand_word());
        else if (r < 94) queue_op(OP_SORT_ASC, $urandom_range(127), $urandom);
        else             queue_op(OP_SORT_DESC, $urandom_range(127), $urandom);
      end else begin
        queue_op(3'($urandom_range(7)), $urandom_range(127), $urandom);
      end
    end

    // Wait until every op is in and every result has come back, then idle on.
    while (!(pending_ops.size() == 0 && !drv_valid && expected_results.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results still outstanding", 64'(expected_results.size()), 64'd0);
    if (n_errors == 0) begin
      $display("[array_store_sort_insert_delete_top] OK");
    end else begin
      $display("[array_store_sort_insert_delete_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
